/* rtl/ecd_pkg.sv */
// ----------------------------------------------------------------------------
// ecd_pkg
// Shared types and codes for the event coalescer with deadline.
// ----------------------------------------------------------------------------
package ecd_pkg;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DRAIN   = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    K_DRAINED    = 3'd0,
    K_ACCEPTED   = 3'd1,
    K_FULL       = 3'd2,
    K_DRAIN_DONE = 3'd3,
    K_CLEAR_DONE = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    REG_CHANGE_LIMIT = 2'd0,
    REG_BYTE_LIMIT   = 2'd1,
    REG_MIN_DELAY    = 2'd2,
    REG_MAX_DELAY    = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ_SCAN,
    S_ENQ_WRITE,
    S_DRN_SCAN,
    S_CLEAR
  } state_t;

  // One queued command.
  typedef struct packed {
    opcode_t     opcode;
    logic [31:0] doc_key;
    logic [31:0] snapshot_handle;
    logic [31:0] text_bytes;
    logic [31:0] now_ms;
  } cmd_t;

  // Effective configuration, zero values already replaced.
  typedef struct packed {
    logic [15:0] change_limit;
    logic [31:0] byte_limit;
    logic [15:0] min_delay;
    logic [15:0] max_delay;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] out_key;
    logic [31:0] out_handle;
    logic        snapshot_only;
    logic [15:0] change_count;
    logic        next_valid;
    logic [31:0] next_ready_ms;
    logic        last;
  } result_t;

  localparam int QUEUE_DEPTH = 2;

endpackage

/* rtl/event_coalescer_with_deadline.sv */
// ----------------------------------------------------------------------------
// event_coalescer_with_deadline
// Per-key change coalescing with quiet time and hard deadline.
// ----------------------------------------------------------------------------
// Enqueue: a dispatch step, one table pass and one update step, then the result.
// Drain: a dispatch step, then one table pass per drained entry plus one more
//   pass for the closing result; the single read port sets this.
// Clear: dispatch, then the clear state. A two-deep command queue takes items while the table works.
// Reset empties the table and the queue and loads the default registers.
// Results are strobed for one cycle; the receiver cannot stall.
module event_coalescer_with_deadline #(
  parameter int ENTRIES   = 16,
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [31:0] doc_key,
  input  logic [31:0] snapshot_handle,
  input  logic [31:0] text_bytes,
  input  logic [31:0] now_ms,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        strobe,
  output logic [2:0]  kind,
  output logic [31:0] out_key,
  output logic [31:0] out_handle,
  output logic        snapshot_only,
  output logic [15:0] change_count,
  output logic        next_valid,
  output logic [31:0] next_ready_ms,
  output logic        last
);

  logic [15:0] change_limit;
  logic [31:0] byte_limit;
  logic [15:0] min_delay_ms;
  logic [15:0] max_delay_ms;
  logic [15:0] eff_min;

  ecd_pkg::cfg_t    cfg;
  ecd_pkg::cmd_t    cmd_in;
  ecd_pkg::cmd_t    cmd_head;
  ecd_pkg::result_t result;
  logic             cmd_valid;
  logic             pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      change_limit <= 16'd64;
      byte_limit   <= 32'd65536;
      min_delay_ms <= 16'd8;
      max_delay_ms <= 16'd16;
    end else if (cfg_we) begin
      unique case (ecd_pkg::reg_index_t'(cfg_index))
        ecd_pkg::REG_CHANGE_LIMIT: change_limit <= cfg_data[15:0];
        ecd_pkg::REG_BYTE_LIMIT:   byte_limit   <= cfg_data;
        ecd_pkg::REG_MIN_DELAY:    min_delay_ms <= cfg_data[15:0];
        ecd_pkg::REG_MAX_DELAY:    max_delay_ms <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign eff_min = (min_delay_ms != '0) ? min_delay_ms : 16'd1;
  assign cfg.change_limit = (change_limit != '0) ? change_limit : 16'd1;
  assign cfg.byte_limit   = (byte_limit != '0) ? byte_limit : 32'd1;
  assign cfg.min_delay    = eff_min;
  assign cfg.max_delay    = (max_delay_ms > eff_min) ? max_delay_ms : eff_min;

  assign cmd_in.opcode          = ecd_pkg::opcode_t'(opcode);
  assign cmd_in.doc_key         = doc_key;
  assign cmd_in.snapshot_handle = snapshot_handle;
  assign cmd_in.text_bytes      = text_bytes;
  assign cmd_in.now_ms          = now_ms;

  ecd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd_in    (cmd_in),
    .cmd_valid (cmd_valid),
    .cmd_head  (cmd_head),
    .pop       (pop)
  );

  ecd_back #(.ENTRIES(ENTRIES), .TIME_BITS(TIME_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd_head  (cmd_head),
    .pop       (pop),
    .strobe    (strobe),
    .result    (result)
  );

  assign kind          = result.kind;
  assign out_key       = result.out_key;
  assign out_handle    = result.out_handle;
  assign snapshot_only = result.snapshot_only;
  assign change_count  = result.change_count;
  assign next_valid    = result.next_valid;
  assign next_ready_ms = result.next_ready_ms;
  assign last          = result.last;

  // a drained entry is never the closing transaction of a drain
  a_drained_not_last: assert property (@(posedge clk) disable iff (rst)
    strobe && kind == ecd_pkg::K_DRAINED |-> !last)
    else $error("drained entry marked last");

  a_other_last: assert property (@(posedge clk) disable iff (rst)
    strobe && kind != ecd_pkg::K_DRAINED |-> last)
    else $error("single result not marked last");

  // a closing result is never followed at once by another strobe
  a_no_back_to_back_last: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe)
    else $error("result right after a closing result");

  a_empty_drain: assert property (@(posedge clk) disable iff (rst)
    strobe && kind == ecd_pkg::K_DRAIN_DONE && !next_valid |-> next_ready_ms == '0)
    else $error("next ready time without pending entry");

endmodule

/* rtl/ecd_ram.sv */
// ----------------------------------------------------------------------------
// ecd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ecd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/ecd_front.sv */
// ----------------------------------------------------------------------------
// ecd_front
// Takes commands, drops the unused opcode and queues the rest for the back end.
// ----------------------------------------------------------------------------
module ecd_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  ecd_pkg::cmd_t  cmd_in,
  output logic           cmd_valid,
  output ecd_pkg::cmd_t  cmd_head,
  input  logic           pop
);

  localparam int PW = $clog2(ecd_pkg::QUEUE_DEPTH);

  ecd_pkg::cmd_t q [ecd_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          push;
  logic          do_pop;

  assign busy      = (count == (PW+1)'(ecd_pkg::QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd_head  = q[rd_ptr];
  assign push      = start && !busy && (cmd_in.opcode != ecd_pkg::OP_NONE);
  assign do_pop    = pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(do_pop);
    end
  end

endmodule

/* rtl/ecd_back.sv */
// ----------------------------------------------------------------------------
// ecd_back
// Slot table and sequencer: scans the table one slot per cycle for
// enqueue lookups and for ordered drains.
// ----------------------------------------------------------------------------
module ecd_back #(
  parameter int ENTRIES   = 16,
  parameter int TIME_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  ecd_pkg::cfg_t     cfg,
  input  logic              cmd_valid,
  input  ecd_pkg::cmd_t     cmd_head,
  output logic              pop,
  output logic              strobe,
  output ecd_pkg::result_t  result
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int TB = TIME_BITS;
  localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;
  // entry layout from the LSB: flag, bytes, changes, deadline, ready, handle, key
  localparam int O_BYTES = 1;
  localparam int O_CHG   = 33;
  localparam int O_DL    = 49;
  localparam int O_RDY   = 49 + TB;
  localparam int O_HDL   = 49 + 2*TB;
  localparam int O_KEY   = 81 + 2*TB;
  localparam int EW      = 113 + 2*TB;

  ecd_pkg::state_t state, state_next;
  ecd_pkg::cmd_t   cmd;

  logic [ENTRIES-1:0] valid;
  logic [IW:0]        cnt;
  logic               rd_pend;
  logic [IW-1:0]      rd_idx;
  logic               scan_end;

  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [EW-1:0]      ram_wdata;
  logic [EW-1:0]      rdata;

  logic               hit_found;
  logic [IW-1:0]      hit_idx;
  logic [EW-1:0]      hit_data;
  logic               free_found;
  logic [IW-1:0]      free_idx;

  logic               best_found;
  logic [IW-1:0]      best_idx;
  logic [31:0]        best_key;
  logic [31:0]        best_handle;
  logic               best_flag;
  logic [15:0]        best_chg;
  logic               nv;
  logic [TB-1:0]      nr;

  logic               strobe_next;
  ecd_pkg::result_t   result_next;

  // fields of the slot being read
  logic [31:0]   r_key;
  logic [TB-1:0] r_rdy;
  logic [TB-1:0] r_dl;
  logic [TB-1:0] r_min;
  logic          r_valid;
  logic          r_due;
  logic [CW-1:0] now_c;

  // enqueue update
  logic [TB-1:0] t_ready;
  logic [TB-1:0] t_dead;
  logic [15:0]   h_chg;
  logic [32:0]   h_sum;
  logic [31:0]   h_bytes;
  logic          h_flag;
  logic [TB-1:0] h_dl;
  logic [TB-1:0] h_ready;

  function automatic logic [TB-1:0] time_add(input logic [CW-1:0] now,
                                             input logic [15:0] d);
    logic [TB:0] s;
    s = {1'b0, now[TB-1:0]} + (TB+1)'(d);
    return s[TB] ? {TB{1'b1}} : s[TB-1:0];
  endfunction

  ecd_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt[IW-1:0]),
    .rdata (rdata)
  );

  assign now_c    = CW'(cmd.now_ms);
  assign r_key    = rdata[O_KEY +: 32];
  assign r_rdy    = rdata[O_RDY +: TB];
  assign r_dl     = rdata[O_DL +: TB];
  assign r_min    = (r_rdy < r_dl) ? r_rdy : r_dl;
  assign r_valid  = rd_pend && valid[rd_idx];
  assign r_due    = r_valid && !((now_c < CW'(r_rdy)) && (now_c < CW'(r_dl)));
  assign scan_end = (cnt == (IW+1)'(ENTRIES)) && !rd_pend;

  assign t_ready = time_add(now_c, cfg.min_delay);
  assign t_dead  = time_add(now_c, cfg.max_delay);
  assign h_chg   = (hit_data[O_CHG +: 16] == 16'hFFFF) ? 16'hFFFF
                                                       : hit_data[O_CHG +: 16] + 16'd1;
  assign h_sum   = {1'b0, hit_data[O_BYTES +: 32]} + {1'b0, cmd.text_bytes};
  assign h_bytes = h_sum[32] ? 32'hFFFF_FFFF : h_sum[31:0];
  assign h_flag  = hit_data[0] || (h_chg > cfg.change_limit) || (h_bytes > cfg.byte_limit);
  assign h_dl    = hit_data[O_DL +: TB];
  assign h_ready = (t_ready < h_dl) ? t_ready : h_dl;

  always_comb begin
    state_next = state;
    unique case (state)
      ecd_pkg::S_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd_head.opcode)
            ecd_pkg::OP_ENQUEUE: state_next = ecd_pkg::S_ENQ_SCAN;
            ecd_pkg::OP_DRAIN:   state_next = ecd_pkg::S_DRN_SCAN;
            default:             state_next = ecd_pkg::S_CLEAR;
          endcase
        end
      end
      ecd_pkg::S_ENQ_SCAN:  if (scan_end) state_next = ecd_pkg::S_ENQ_WRITE;
      ecd_pkg::S_ENQ_WRITE: state_next = ecd_pkg::S_IDLE;
      ecd_pkg::S_DRN_SCAN:  if (scan_end && !best_found) state_next = ecd_pkg::S_IDLE;
      ecd_pkg::S_CLEAR:     state_next = ecd_pkg::S_IDLE;
      default:              state_next = ecd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    pop         = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = hit_found ? hit_idx : free_idx;
    ram_wdata   = '0;
    strobe_next = 1'b0;
    result_next = '0;
    unique case (state)
      ecd_pkg::S_IDLE: pop = cmd_valid;
      ecd_pkg::S_ENQ_WRITE: begin
        strobe_next      = 1'b1;
        result_next.last = 1'b1;
        result_next.kind = ecd_pkg::K_ACCEPTED;
        if (hit_found) begin
          ram_we    = 1'b1;
          ram_wdata = {hit_data[O_KEY +: 32], cmd.snapshot_handle, h_ready, h_dl,
                       h_chg, h_bytes, h_flag};
        end else if (free_found) begin
          ram_we    = 1'b1;
          ram_wdata = {cmd.doc_key, cmd.snapshot_handle, t_ready, t_dead, 16'd1,
                       cmd.text_bytes, (cmd.text_bytes > cfg.byte_limit)};
        end else begin
          result_next.kind = ecd_pkg::K_FULL;
        end
      end
      ecd_pkg::S_DRN_SCAN: begin
        if (scan_end) begin
          strobe_next = 1'b1;
          if (best_found) begin
            result_next.kind          = ecd_pkg::K_DRAINED;
            result_next.out_key       = best_key;
            result_next.out_handle    = best_handle;
            result_next.snapshot_only = best_flag;
            result_next.change_count  = best_chg;
          end else begin
            result_next.kind          = ecd_pkg::K_DRAIN_DONE;
            result_next.next_valid    = nv;
            result_next.next_ready_ms = 32'(CW'(nr));
            result_next.last          = 1'b1;
          end
        end
      end
      ecd_pkg::S_CLEAR: begin
        strobe_next      = 1'b1;
        result_next.kind = ecd_pkg::K_CLEAR_DONE;
        result_next.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ecd_pkg::S_IDLE;
      valid  <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= strobe_next;
      if (state == ecd_pkg::S_CLEAR) begin
        valid <= '0;
      end
      if (state == ecd_pkg::S_ENQ_WRITE && !hit_found && free_found) begin
        valid[free_idx] <= 1'b1;
      end
      if (state == ecd_pkg::S_DRN_SCAN && scan_end && best_found) begin
        valid[best_idx] <= 1'b0;
      end
    end
  end

  // scan pointer and trackers
  always_ff @(posedge clk) begin
    result <= result_next;
    if (state == ecd_pkg::S_IDLE ||
        (state == ecd_pkg::S_DRN_SCAN && scan_end)) begin
      if (state == ecd_pkg::S_IDLE) begin
        cmd <= cmd_head;
      end
      cnt        <= '0;
      rd_pend    <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      best_found <= 1'b0;
      nv         <= 1'b0;
      nr         <= '0;
    end else if (state == ecd_pkg::S_ENQ_SCAN || state == ecd_pkg::S_DRN_SCAN) begin
      if (cnt != (IW+1)'(ENTRIES)) begin
        cnt     <= cnt + 1'b1;
        rd_pend <= 1'b1;
        rd_idx  <= cnt[IW-1:0];
      end else begin
        rd_pend <= 1'b0;
      end
      if (rd_pend) begin
        if (state == ecd_pkg::S_ENQ_SCAN) begin
          if (r_valid && r_key == cmd.doc_key && !hit_found) begin
            hit_found <= 1'b1;
            hit_idx   <= rd_idx;
            hit_data  <= rdata;
          end
          if (!valid[rd_idx] && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= rd_idx;
          end
        end else begin
          if (r_due && (!best_found || r_key < best_key)) begin
            best_found  <= 1'b1;
            best_idx    <= rd_idx;
            best_key    <= r_key;
            best_handle <= rdata[O_HDL +: 32];
            best_flag   <= rdata[0];
            best_chg    <= rdata[O_CHG +: 16];
          end
          // valid slots that are not due remain after the drain
          if (r_valid && !r_due && (!nv || r_min < nr)) begin
            nv <= 1'b1;
            nr <= r_min;
          end
        end
      end
    end
  end

endmodule
